// ===== src/cab_pkg.sv =====
`timescale 1ns / 1ps

package cab_pkg;

    localparam int NUM_LANES      = 5;
    localparam int ALIGN_BITS     = 21;
    localparam int LIMIT_MIN_BITS = 28;
    localparam int REG_IDX_W      = 3;

    localparam logic [ALIGN_BITS-1:0] DEFAULT_ALIGN = ALIGN_BITS'(16);
    localparam longint unsigned DEFAULT_LIMIT = 128 * 1024 * 1024;

    localparam int LANE_VERTEX     = 0;
    localparam int LANE_ATTRIBUTE  = 1;
    localparam int LANE_INDEX      = 2;
    localparam int LANE_MESH       = 3;
    localparam int LANE_MESH_INDEX = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_VERTEX_ALIGN           = 3'd0,
        REG_ATTRIBUTE_ALIGN        = 3'd1,
        REG_COMMON_ALIGN           = 3'd2,
        REG_VERTEX_CHUNK_LIMIT     = 3'd3,
        REG_INDEX_CHUNK_LIMIT      = 3'd4,
        REG_MESH_CHUNK_LIMIT       = 3'd5,
        REG_MESH_INDEX_CHUNK_LIMIT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic over_fill;
        logic over_alone;
    } t_lane_flags;

endpackage

// ===== src/cab_req_if.sv =====
`timescale 1ns / 1ps

interface cab_req_if #(
    parameter int SIZE_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] vertex_bytes;
    logic [SIZE_BITS-1:0] attribute_bytes;
    logic [SIZE_BITS-1:0] index_bytes;
    logic [SIZE_BITS-1:0] mesh_bytes;
    logic [SIZE_BITS-1:0] mesh_index_bytes;

    modport source (
        output valid, vertex_bytes, attribute_bytes, index_bytes, mesh_bytes,
               mesh_index_bytes,
        input  ready
    );

    modport sink (
        input  valid, vertex_bytes, attribute_bytes, index_bytes, mesh_bytes,
               mesh_index_bytes,
        output ready
    );
endinterface

// ===== src/cab_rsp_if.sv =====
`timescale 1ns / 1ps

interface cab_rsp_if #(
    parameter int SIZE_BITS  = 32,
    parameter int CHUNK_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [CHUNK_BITS-1:0] chunk_number;
    logic [SIZE_BITS-1:0]  vertex_offset;
    logic [SIZE_BITS-1:0]  attribute_offset;
    logic [SIZE_BITS-1:0]  index_offset;
    logic [SIZE_BITS-1:0]  mesh_offset;
    logic [SIZE_BITS-1:0]  mesh_index_offset;
    logic                  opened_chunk;
    logic                  oversize;

    modport source (
        output valid, chunk_number, vertex_offset, attribute_offset, index_offset,
               mesh_offset, mesh_index_offset, opened_chunk, oversize,
        input  ready
    );

    modport sink (
        input  valid, chunk_number, vertex_offset, attribute_offset, index_offset,
               mesh_offset, mesh_index_offset, opened_chunk, oversize,
        output ready
    );
endinterface

// ===== src/cab_lane.sv =====
`timescale 1ns / 1ps

module cab_lane import cab_pkg::*; #(
    parameter int SIZE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SIZE_BITS-1:0]  i_size,
    input  logic [ALIGN_BITS-1:0] i_align,
    input  logic [SIZE_BITS:0]    i_fill,
    input  logic [((SIZE_BITS > LIMIT_MIN_BITS) ? SIZE_BITS : LIMIT_MIN_BITS)-1:0] i_limit,
    output logic                  o_done,
    output logic [((SIZE_BITS > ALIGN_BITS) ? SIZE_BITS : ALIGN_BITS):0] o_rounded,
    output t_lane_flags           o_flags
);

    localparam int LIM_W  = (SIZE_BITS > LIMIT_MIN_BITS) ? SIZE_BITS : LIMIT_MIN_BITS;
    localparam int RND_W  = ((SIZE_BITS > ALIGN_BITS) ? SIZE_BITS : ALIGN_BITS) + 1;
    localparam int CMP_W  = ((RND_W > LIM_W) ? RND_W : LIM_W) + 1;
    localparam int CNT_W  = $clog2(SIZE_BITS);

    typedef enum logic [2:0] {
        L_IDLE,
        L_DIV,
        L_ROUND,
        L_CHECK,
        L_DONE
    } t_lane_state;

    t_lane_state           r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [SIZE_BITS-1:0]  r_size;
    logic [SIZE_BITS-1:0]  r_shift;
    logic [ALIGN_BITS-1:0] r_rem;
    logic [RND_W-1:0]      r_rounded;
    t_lane_flags           r_flags;

    logic [ALIGN_BITS-1:0] w_align_eff;
    logic [ALIGN_BITS:0]   w_rem_sh;
    logic [ALIGN_BITS:0]   w_rem_sub;
    logic [ALIGN_BITS-1:0] w_rem_next;
    logic [ALIGN_BITS-1:0] w_pad;
    logic [CMP_W-1:0]      w_sum;
    logic [CMP_W-1:0]      w_limit_ext;
    logic [CMP_W-1:0]      w_rnd_ext;

    assign w_align_eff = (i_align == '0) ? ALIGN_BITS'(1) : i_align;
    assign w_rem_sh    = {r_rem, r_shift[SIZE_BITS-1]};
    assign w_rem_sub   = w_rem_sh - {1'b0, w_align_eff};
    assign w_rem_next  = (w_rem_sh >= {1'b0, w_align_eff}) ? w_rem_sub[ALIGN_BITS-1:0]
                                                            : w_rem_sh[ALIGN_BITS-1:0];
    assign w_pad       = (r_rem == '0) ? '0 : (w_align_eff - r_rem);
    assign w_rnd_ext   = CMP_W'(r_rounded);
    assign w_limit_ext = CMP_W'(i_limit);
    assign w_sum       = CMP_W'(i_fill) + w_rnd_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            unique case (r_state)
                L_IDLE, L_DONE: begin
                    if (i_start) begin
                        r_size  <= i_size;
                        r_shift <= i_size;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(SIZE_BITS - 1);
                        r_state <= L_DIV;
                    end
                end
                L_DIV: begin
                    r_rem   <= w_rem_next;
                    r_shift <= {r_shift[SIZE_BITS-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= L_ROUND;
                    end
                end
                L_ROUND: begin
                    r_rounded <= RND_W'(r_size) + RND_W'(w_pad);
                    r_state   <= L_CHECK;
                end
                L_CHECK: begin
                    r_flags.over_fill  <= w_sum > w_limit_ext;
                    r_flags.over_alone <= w_rnd_ext > w_limit_ext;
                    r_state            <= L_DONE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done    = (r_state == L_DONE);
    assign o_rounded = r_rounded;
    assign o_flags   = r_flags;

endmodule

// ===== src/chunked_aligned_bump_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Modport          Transaction
// i_req     cab_req_if.sink  five byte sizes of one allocation request
// o_rsp     cab_rsp_if.source chunk number, five offsets, opened/oversize flags
// i_cfg_*   plain write      alignment and chunk limit registers, index 0..6
//
// From accept to result, each lane runs its one-bit-per-cycle remainder loop,
// then its rounding and limit-check states, before the result is registered.
// Requests are taken one at a time; the next is accepted as soon as the previous
// result is registered, even while that result still waits on o_rsp.ready.
// A stalled output holds finished lane results until the output register frees.
// Synchronous active-low reset restores default registers and closes the chunk.

module chunked_aligned_bump_allocator import cab_pkg::*; #(
    parameter int SIZE_BITS  = 32,
    parameter int CHUNK_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cab_req_if.sink              i_req,
    cab_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [((SIZE_BITS > ALIGN_BITS) ? SIZE_BITS : ALIGN_BITS)-1:0] i_cfg_data
);

    localparam int LIM_W  = (SIZE_BITS > LIMIT_MIN_BITS) ? SIZE_BITS : LIMIT_MIN_BITS;
    localparam int RND_W  = ((SIZE_BITS > ALIGN_BITS) ? SIZE_BITS : ALIGN_BITS) + 1;
    localparam int FILL_W = SIZE_BITS + 1;
    localparam logic [CHUNK_BITS-1:0] CHUNK_TOP = '1;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    logic [ALIGN_BITS-1:0] r_vertex_align;
    logic [ALIGN_BITS-1:0] r_attribute_align;
    logic [ALIGN_BITS-1:0] r_common_align;
    logic [LIM_W-1:0]      r_vertex_limit;
    logic [LIM_W-1:0]      r_index_limit;
    logic [LIM_W-1:0]      r_mesh_limit;
    logic [LIM_W-1:0]      r_mesh_index_limit;

    t_state                r_state;
    logic                  r_chunk_open;
    logic [CHUNK_BITS-1:0] r_chunk;
    logic [FILL_W-1:0]     r_fill [NUM_LANES];
    logic                  r_out_valid;
    logic [CHUNK_BITS-1:0] r_out_chunk;
    logic [SIZE_BITS-1:0]  r_out_offset [NUM_LANES];
    logic                  r_out_opened;
    logic                  r_out_over;

    logic [SIZE_BITS-1:0]  w_size  [NUM_LANES];
    logic [ALIGN_BITS-1:0] w_align [NUM_LANES];
    logic [LIM_W-1:0]      w_limit [NUM_LANES];
    logic [RND_W-1:0]      w_rounded [NUM_LANES];
    t_lane_flags           w_flags [NUM_LANES];
    logic [NUM_LANES-1:0]  w_done;
    logic [NUM_LANES-1:0]  w_over_fill;
    logic [NUM_LANES-1:0]  w_over_alone;
    logic [FILL_W-1:0]     w_base [NUM_LANES];
    logic [RND_W-1:0]      w_sum  [NUM_LANES];
    logic [FILL_W-1:0]     n_fill [NUM_LANES];
    logic [CHUNK_BITS-1:0] n_chunk;

    logic w_start;
    logic w_out_free;
    logic w_fire;
    logic w_need_new;
    logic w_over;

    assign w_size[LANE_VERTEX]     = i_req.vertex_bytes;
    assign w_size[LANE_ATTRIBUTE]  = i_req.attribute_bytes;
    assign w_size[LANE_INDEX]      = i_req.index_bytes;
    assign w_size[LANE_MESH]       = i_req.mesh_bytes;
    assign w_size[LANE_MESH_INDEX] = i_req.mesh_index_bytes;

    assign w_align[LANE_VERTEX]     = r_vertex_align;
    assign w_align[LANE_ATTRIBUTE]  = r_attribute_align;
    assign w_align[LANE_INDEX]      = r_common_align;
    assign w_align[LANE_MESH]       = r_common_align;
    assign w_align[LANE_MESH_INDEX] = r_common_align;

    assign w_limit[LANE_VERTEX]     = r_vertex_limit;
    assign w_limit[LANE_ATTRIBUTE]  = r_vertex_limit;
    assign w_limit[LANE_INDEX]      = r_index_limit;
    assign w_limit[LANE_MESH]       = r_mesh_limit;
    assign w_limit[LANE_MESH_INDEX] = r_mesh_index_limit;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_start     = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_fire      = (r_state == S_RUN) && (&w_done) && w_out_free;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        cab_lane #(
            .SIZE_BITS (SIZE_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_start),
            .i_size    (w_size[g]),
            .i_align   (w_align[g]),
            .i_fill    (r_fill[g]),
            .i_limit   (w_limit[g]),
            .o_done    (w_done[g]),
            .o_rounded (w_rounded[g]),
            .o_flags   (w_flags[g])
        );

        assign w_over_fill[g]  = w_flags[g].over_fill;
        assign w_over_alone[g] = w_flags[g].over_alone;
        assign w_base[g]       = w_need_new ? '0 : r_fill[g];
        assign w_sum[g]        = RND_W'(w_base[g]) + w_rounded[g];
        assign n_fill[g]       = w_sum[g][FILL_W-1:0];
    end

    assign w_need_new = !r_chunk_open || (|w_over_fill);
    assign w_over     = |w_over_alone;

    always_comb begin
        n_chunk = r_chunk;
        if (w_need_new) begin
            if (!r_chunk_open) begin
                n_chunk = '0;
            end else if (r_chunk != CHUNK_TOP) begin
                n_chunk = r_chunk + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_align     <= DEFAULT_ALIGN;
            r_attribute_align  <= DEFAULT_ALIGN;
            r_common_align     <= DEFAULT_ALIGN;
            r_vertex_limit     <= LIM_W'(DEFAULT_LIMIT);
            r_index_limit      <= LIM_W'(DEFAULT_LIMIT);
            r_mesh_limit       <= LIM_W'(DEFAULT_LIMIT);
            r_mesh_index_limit <= LIM_W'(DEFAULT_LIMIT);
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_VERTEX_ALIGN:           r_vertex_align     <= i_cfg_data[ALIGN_BITS-1:0];
                REG_ATTRIBUTE_ALIGN:        r_attribute_align  <= i_cfg_data[ALIGN_BITS-1:0];
                REG_COMMON_ALIGN:           r_common_align     <= i_cfg_data[ALIGN_BITS-1:0];
                REG_VERTEX_CHUNK_LIMIT:     r_vertex_limit     <= LIM_W'(i_cfg_data[SIZE_BITS-1:0]);
                REG_INDEX_CHUNK_LIMIT:      r_index_limit      <= LIM_W'(i_cfg_data[SIZE_BITS-1:0]);
                REG_MESH_CHUNK_LIMIT:       r_mesh_limit       <= LIM_W'(i_cfg_data[SIZE_BITS-1:0]);
                REG_MESH_INDEX_CHUNK_LIMIT: r_mesh_index_limit <= LIM_W'(i_cfg_data[SIZE_BITS-1:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_chunk_open <= 1'b0;
            r_chunk      <= '0;
            for (int i = 0; i < NUM_LANES; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_fire) begin
                        r_state      <= S_IDLE;
                        r_out_chunk  <= n_chunk;
                        r_out_opened <= w_need_new;
                        r_out_over   <= w_over;
                        r_chunk_open <= 1'b1;
                        r_chunk      <= n_chunk;
                        for (int i = 0; i < NUM_LANES; i++) begin
                            r_out_offset[i] <= w_base[i][SIZE_BITS-1:0];
                            r_fill[i]       <= n_fill[i];
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.chunk_number      = r_out_chunk;
    assign o_rsp.vertex_offset     = r_out_offset[LANE_VERTEX];
    assign o_rsp.attribute_offset  = r_out_offset[LANE_ATTRIBUTE];
    assign o_rsp.index_offset      = r_out_offset[LANE_INDEX];
    assign o_rsp.mesh_offset       = r_out_offset[LANE_MESH];
    assign o_rsp.mesh_index_offset = r_out_offset[LANE_MESH_INDEX];
    assign o_rsp.opened_chunk      = r_out_opened;
    assign o_rsp.oversize          = r_out_over;

    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && w_done[LANE_VERTEX]) |-> (&w_done))
        else $error("lanes finished out of step");

    a_new_chunk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_need_new) |=> (o_rsp.vertex_offset == '0 &&
            o_rsp.index_offset == '0 && o_rsp.mesh_index_offset == '0 && o_rsp.opened_chunk))
        else $error("new chunk reported nonzero offsets");

    a_chunk_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chunk_open && $past(r_chunk_open)) |-> (r_chunk >= $past(r_chunk)))
        else $error("chunk number went backwards");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_chunk)))
        else $error("pending result overwritten");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cab_pkg::*;

    localparam int SIZE_W  = 32;
    localparam int CHUNK_W = 16;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [NUM_LANES-1:0][SIZE_W-1:0] bytes;
    } t_alloc_req;

    typedef struct packed {
        logic [CHUNK_W-1:0]               chunk;
        logic [NUM_LANES-1:0][SIZE_W-1:0] offset;
        logic                             opened;
        logic                             over;
    } t_alloc_grant;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    cab_req_if #(.SIZE_BITS(SIZE_W)) req_if ();
    cab_rsp_if #(.SIZE_BITS(SIZE_W), .CHUNK_BITS(CHUNK_W)) rsp_if ();

    chunked_aligned_bump_allocator #(
        .SIZE_BITS (SIZE_W),
        .CHUNK_BITS(CHUNK_W)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_rsp     (rsp_if),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // allocator shadow state and registers
    logic [ALIGN_BITS-1:0] align_reg [3];
    logic [SIZE_W-1:0]     limit_reg [4];
    logic                  chunk_live;
    logic [CHUNK_W-1:0]    chunk_cur;
    logic [SIZE_W:0]       lane_fill [NUM_LANES];

    t_alloc_req   request_backlog [$];
    t_alloc_grant pending_grants [$];
    t_alloc_req   next_req;
    t_alloc_req   seen_req;
    t_alloc_grant want;
    t_alloc_grant predicted;

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  req_taken;
    bit  hold_go;
    bit  rsp_hold;
    int  queued_cnt;
    int  requests_taken;
    int  grants_checked;
    int  chunks_opened;
    int  oversize_seen;
    int  settings_used;
    int  mismatch_count;

    function automatic t_alloc_grant predict_allocation(input t_alloc_req rq);
        t_alloc_grant g;
        logic [63:0]  rnd [NUM_LANES];
        logic [63:0]  a;
        logic [63:0]  lim;
        logic         need;
        logic         over;
        need = !chunk_live;
        over = 1'b0;
        for (int l = 0; l < NUM_LANES; l++) begin
            a   = 64'(align_reg[(l < 2) ? l : 2]);
            lim = 64'(limit_reg[(l < 2) ? 0 : l - 1]);
            if (a == 0) begin
                a = 1;
            end
            rnd[l] = ((64'(rq.bytes[l]) + a - 1) / a) * a;
            if (64'(lane_fill[l]) + rnd[l] > lim) begin
                need = 1'b1;
            end
            if (rnd[l] > lim) begin
                over = 1'b1;
            end
        end
        if (need) begin
            if (!chunk_live) begin
                chunk_live = 1'b1;
                chunk_cur  = '0;
            end else if (chunk_cur != '1) begin
                chunk_cur = chunk_cur + 1'b1;
            end
            for (int l = 0; l < NUM_LANES; l++) begin
                lane_fill[l] = '0;
            end
        end
        g.chunk = chunk_cur;
        for (int l = 0; l < NUM_LANES; l++) begin
            g.offset[l]  = lane_fill[l][SIZE_W-1:0];
            lane_fill[l] = (SIZE_W+1)'(64'(lane_fill[l]) + rnd[l]);
        end
        g.opened = need;
        g.over   = over;
        return g;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ns: mismatch on %s, expected %0h actual %0h", $time, name,
                     exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // driver: requests and response backpressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (!req_if.valid || req_taken) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = request_backlog.pop_front();
                    req_if.valid            <= 1'b1;
                    req_if.vertex_bytes     <= next_req.bytes[LANE_VERTEX];
                    req_if.attribute_bytes  <= next_req.bytes[LANE_ATTRIBUTE];
                    req_if.index_bytes      <= next_req.bytes[LANE_INDEX];
                    req_if.mesh_bytes       <= next_req.bytes[LANE_MESH];
                    req_if.mesh_index_bytes <= next_req.bytes[LANE_MESH_INDEX];
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            req_taken = 1'b0;
            rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on accept, compare on result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                seen_req.bytes[LANE_VERTEX]     = req_if.vertex_bytes;
                seen_req.bytes[LANE_ATTRIBUTE]  = req_if.attribute_bytes;
                seen_req.bytes[LANE_INDEX]      = req_if.index_bytes;
                seen_req.bytes[LANE_MESH]       = req_if.mesh_bytes;
                seen_req.bytes[LANE_MESH_INDEX] = req_if.mesh_index_bytes;
                predicted      = predict_allocation(seen_req);
                pending_grants = {pending_grants, predicted};
                requests_taken++;
                req_taken = 1'b1;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_grants.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none actual chunk %0h",
                             $time, rsp_if.chunk_number);
                    mismatch_count++;
                end else begin
                    want = pending_grants.pop_front();
                    check_field("chunk_number", 32'(want.chunk), 32'(rsp_if.chunk_number));
                    check_field("vertex_offset", want.offset[LANE_VERTEX],
                                rsp_if.vertex_offset);
                    check_field("attribute_offset", want.offset[LANE_ATTRIBUTE],
                                rsp_if.attribute_offset);
                    check_field("index_offset", want.offset[LANE_INDEX],
                                rsp_if.index_offset);
                    check_field("mesh_offset", want.offset[LANE_MESH], rsp_if.mesh_offset);
                    check_field("mesh_index_offset", want.offset[LANE_MESH_INDEX],
                                rsp_if.mesh_index_offset);
                    check_field("opened_chunk", 32'(want.opened), 32'(rsp_if.opened_chunk));
                    check_field("oversize", 32'(want.over), 32'(rsp_if.oversize));
                    grants_checked++;
                    chunks_opened += int'(rsp_if.opened_chunk);
                    oversize_seen += int'(rsp_if.oversize);
                end
            end
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_go);
        rsp_hold = 1'b1;
        repeat (400) @(negedge i_clk);
        rsp_hold = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("%0t ns: timeout, %0d results still outstanding", $time,
                 pending_grants.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic enqueue(input logic [31:0] v, input logic [31:0] a, input logic [31:0] ix,
                           input logic [31:0] m, input logic [31:0] mi);
        t_alloc_req r;
        r.bytes[LANE_VERTEX]     = v;
        r.bytes[LANE_ATTRIBUTE]  = a;
        r.bytes[LANE_INDEX]      = ix;
        r.bytes[LANE_MESH]       = m;
        r.bytes[LANE_MESH_INDEX] = mi;
        request_backlog = {request_backlog, r};
        queued_cnt++;
    endtask

    task automatic drain();
        while (requests_taken != queued_cnt || pending_grants.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx <= REG_COMMON_ALIGN) begin
            align_reg[idx] = data[ALIGN_BITS-1:0];
        end else if (idx <= REG_MESH_INDEX_CHUNK_LIMIT) begin
            limit_reg[idx - REG_VERTEX_CHUNK_LIMIT] = data;
        end
    endtask

    function automatic logic [31:0] rand_size(input logic [31:0] lim);
        case ($urandom_range(15))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return lim;
            default: return $urandom_range(lim >> 3, 0);
        endcase
    endfunction

    task automatic random_config();
        logic [31:0] v;
        for (int r = REG_VERTEX_ALIGN; r <= REG_MESH_INDEX_CHUNK_LIMIT; r++) begin
            if (r <= REG_COMMON_ALIGN) begin
                case ($urandom_range(7))
                    0:       v = 32'd0;
                    1:       v = 32'd1;
                    2:       v = 32'd1 << $urandom_range(20);
                    3:       v = $urandom_range(1048576, 1);
                    default: v = $urandom_range(64, 1);
                endcase
            end else begin
                case ($urandom_range(5))
                    0:       v = $urandom;
                    1:       v = '1;
                    default: v = $urandom_range(32'd1 << $urandom_range(24, 8), 1);
                endcase
            end
            write_reg(r[2:0], v);
        end
        settings_used++;
    endtask

    task automatic random_block(input int n);
        for (int k = 0; k < n; k++) begin
            enqueue(rand_size(limit_reg[0]), rand_size(limit_reg[0]), rand_size(limit_reg[1]),
                    rand_size(limit_reg[2]), rand_size(limit_reg[3]));
        end
    endtask

    initial begin
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        req_if.valid            = 1'b0;
        req_if.vertex_bytes     = '0;
        req_if.attribute_bytes  = '0;
        req_if.index_bytes      = '0;
        req_if.mesh_bytes       = '0;
        req_if.mesh_index_bytes = '0;
        rsp_if.ready            = 1'b0;
        for (int k = 0; k < 3; k++) begin
            align_reg[k] = DEFAULT_ALIGN;
        end
        for (int k = 0; k < 4; k++) begin
            limit_reg[k] = 32'(DEFAULT_LIMIT);
        end
        chunk_live = 1'b0;
        chunk_cur  = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            lane_fill[k] = '0;
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_used  = 1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: first request, rounding, exact fit, oversize, refill
        enqueue(0, 0, 0, 0, 0);
        enqueue(1, 1, 1, 1, 1);
        enqueue(17, 15, 16, 33, 2);
        enqueue('1, 0, 0, 0, 0);
        enqueue(0, 0, 0, 0, 0);
        enqueue(0, '1, '1, '1, '1);
        enqueue(32'(DEFAULT_LIMIT), 0, 0, 0, 0);
        enqueue(16, 0, 0, 0, 0);
        drain();

        // zero and largest power-of-two alignments, masked upper bits, zero and full limits
        write_reg(REG_VERTEX_ALIGN, 32'd0);
        write_reg(REG_ATTRIBUTE_ALIGN, 32'd1048576);
        write_reg(REG_COMMON_ALIGN, 32'h0200_0003);
        write_reg(REG_VERTEX_CHUNK_LIMIT, '1);
        write_reg(REG_INDEX_CHUNK_LIMIT, 32'd0);
        write_reg(REG_MESH_CHUNK_LIMIT, 32'd1);
        write_reg(REG_MESH_INDEX_CHUNK_LIMIT, 32'd100);
        write_reg(REG_UNUSED, 32'd5);
        settings_used++;
        enqueue(5, 1, 0, 0, 0);
        enqueue(0, 0, 1, 0, 0);
        enqueue('1, 0, 0, 0, 0);
        enqueue(1, 0, 0, 0, 0);
        enqueue(0, '1, 0, 0, 0);
        enqueue(0, 0, 0, 1, 0);
        enqueue(0, 0, 0, 0, 0);
        enqueue(0, 0, 0, 0, 99);
        enqueue(0, 0, 0, 0, 1);
        enqueue(0, 32'h0010_0001, 0, 0, 98);
        drain();

        random_config();
        hold_go = 1'b1;
        random_block(12);
        drain();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            for (int k = 0; k < 2; k++) begin
                random_config();
                random_block(65);
                drain();
            end
        end

        repeat (40) @(posedge i_clk);
        if (pending_grants.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, pending_grants.size());
            mismatch_count++;
        end
        $display("Covered %0d allocation requests over %0d register settings, %0d results checked",
                 requests_taken, settings_used, grants_checked);
        $display("Results opened %0d chunks and flagged %0d oversize requests",
                 chunks_opened, oversize_seen);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
